// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Shared widths and the queue item type for the rotation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    localparam int CW     = 16;            // width of every input component
    localparam int QQ_W   = 2 * CW;        // product of two components
    localparam int M_W    = QQ_W + 2;      // rotation matrix entry
    localparam int N_W    = QQ_W + 2;      // squared norm
    localparam int P_W    = M_W + CW;      // matrix entry times vector component
    localparam int ACC_W  = P_W + 2;       // sum of three such products
    localparam int OUT_W  = 17;            // rotated component width
    localparam int QB     = OUT_W + 1;     // quotient bits produced by the divider
    localparam int NUM_W  = ACC_W + 2;     // 2*|acc| + N
    localparam int D_W    = N_W + 1;       // 2*N
    localparam int HI_W   = NUM_W - QB;
    localparam int CMP_W  = (HI_W > D_W) ? HI_W : D_W;
    localparam int OUT_MAX_MAG = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN_MAG = 1 << (OUT_W - 1);
    localparam int FRONT_LAT = 4;
    localparam int BACK_LAT  = QB + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int IN_DATA_W  = 7 * CW;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
        logic signed [ACC_W-1:0] acc_z;
        logic        [N_W-1:0]   norm;
        logic                    zero;
    } qvr_item_t;

endpackage

`default_nettype wire

// ===== design/qvr_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate front end
// Forms the unnormalized rotation matrix, the squared norm and the matrix
// times vector sums in four pipeline stages and flags a zero quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_front
    import qvr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [CW-1:0] quat_w,
    input  wire logic signed [CW-1:0] quat_x,
    input  wire logic signed [CW-1:0] quat_y,
    input  wire logic signed [CW-1:0] quat_z,
    input  wire logic signed [CW-1:0] vec_x,
    input  wire logic signed [CW-1:0] vec_y,
    input  wire logic signed [CW-1:0] vec_z,
    output logic                      push,
    input  wire logic                 full,
    output qvr_item_t                 item
);

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [QQ_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [QQ_W-1:0] wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [CW-1:0]   vx1_reg, vy1_reg, vz1_reg;
    logic signed [CW-1:0]   vx2_reg, vy2_reg, vz2_reg;
    logic signed [M_W-1:0]  m00_reg, m01_reg, m02_reg;
    logic signed [M_W-1:0]  m10_reg, m11_reg, m12_reg;
    logic signed [M_W-1:0]  m20_reg, m21_reg, m22_reg;
    logic        [N_W-1:0]  n2_reg, n3_reg;
    logic signed [P_W-1:0]  p00_reg, p01_reg, p02_reg;
    logic signed [P_W-1:0]  p10_reg, p11_reg, p12_reg;
    logic signed [P_W-1:0]  p20_reg, p21_reg, p22_reg;
    qvr_item_t              item_reg;
    logic signed [M_W-1:0]  n_sum;

    assign push     = v4_reg && !full;
    assign en       = !v4_reg || !full;
    assign in_ready = en;
    assign item     = item_reg;

    assign n_sum = M_W'(ww_reg) + M_W'(xx_reg) + M_W'(yy_reg) + M_W'(zz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: the ten distinct component products.
            ww_reg  <= quat_w * quat_w;
            xx_reg  <= quat_x * quat_x;
            yy_reg  <= quat_y * quat_y;
            zz_reg  <= quat_z * quat_z;
            xy_reg  <= quat_x * quat_y;
            wz_reg  <= quat_w * quat_z;
            xz_reg  <= quat_x * quat_z;
            wy_reg  <= quat_w * quat_y;
            yz_reg  <= quat_y * quat_z;
            wx_reg  <= quat_w * quat_x;
            vx1_reg <= vec_x;
            vy1_reg <= vec_y;
            vz1_reg <= vec_z;

            // Stage 2: matrix entries and the squared norm.
            m00_reg <= M_W'(ww_reg) + M_W'(xx_reg) - M_W'(yy_reg) - M_W'(zz_reg);
            m01_reg <= (M_W'(xy_reg) - M_W'(wz_reg)) <<< 1;
            m02_reg <= (M_W'(xz_reg) + M_W'(wy_reg)) <<< 1;
            m10_reg <= (M_W'(xy_reg) + M_W'(wz_reg)) <<< 1;
            m11_reg <= M_W'(ww_reg) - M_W'(xx_reg) + M_W'(yy_reg) - M_W'(zz_reg);
            m12_reg <= (M_W'(yz_reg) - M_W'(wx_reg)) <<< 1;
            m20_reg <= (M_W'(xz_reg) - M_W'(wy_reg)) <<< 1;
            m21_reg <= (M_W'(yz_reg) + M_W'(wx_reg)) <<< 1;
            m22_reg <= M_W'(ww_reg) - M_W'(xx_reg) - M_W'(yy_reg) + M_W'(zz_reg);
            n2_reg  <= N_W'(unsigned'(n_sum));
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;

            // Stage 3: matrix times vector, one product per entry.
            p00_reg <= m00_reg * vx2_reg;
            p01_reg <= m01_reg * vy2_reg;
            p02_reg <= m02_reg * vz2_reg;
            p10_reg <= m10_reg * vx2_reg;
            p11_reg <= m11_reg * vy2_reg;
            p12_reg <= m12_reg * vz2_reg;
            p20_reg <= m20_reg * vx2_reg;
            p21_reg <= m21_reg * vy2_reg;
            p22_reg <= m22_reg * vz2_reg;
            n3_reg  <= n2_reg;

            // Stage 4: row sums and the zero quaternion flag.
            item_reg.acc_x <= ACC_W'(p00_reg) + ACC_W'(p01_reg) + ACC_W'(p02_reg);
            item_reg.acc_y <= ACC_W'(p10_reg) + ACC_W'(p11_reg) + ACC_W'(p12_reg);
            item_reg.acc_z <= ACC_W'(p20_reg) + ACC_W'(p21_reg) + ACC_W'(p22_reg);
            item_reg.norm  <= n3_reg;
            item_reg.zero  <= (n3_reg == '0);
        end
    end

endmodule

`default_nettype wire

// ===== design/qvr_fifo.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate queue
// Short queue that lets the front end and the divider back end stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_fifo
    import qvr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire qvr_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output qvr_item_t      pop_item
);

    qvr_item_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/qvr_div.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate divider lane
// Pipelined restoring divider giving round(acc / N), ties away from zero,
// saturated to the output width; one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_div
    import qvr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [ACC_W-1:0] acc,
    input  wire logic        [N_W-1:0]   norm,
    output logic signed      [OUT_W-1:0] rot
);

    logic              a_neg_reg;
    logic [ACC_W-1:0]  a_mag_reg;
    logic [N_W-1:0]    a_n_reg;
    logic              b_neg_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic [D_W-1:0]    b_d_reg;
    logic [CMP_W-1:0]  hi_ext, d_ext;

    logic [D_W-1:0]    rem_reg [QB+1];
    logic [D_W-1:0]    d_reg   [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic [QB-1:0]     low_reg [QB+1];
    logic              neg_reg [QB+1];
    logic              ovf_reg [QB+1];

    logic [D_W:0]      shifted [QB];
    logic              ge      [QB];

    logic [QB-1:0]     lim, mag_sat, fin;
    logic signed [OUT_W-1:0] rot_reg;

    assign hi_ext = CMP_W'(b_num_reg[NUM_W-1:QB]);
    assign d_ext  = CMP_W'(b_d_reg);

    // Each stage brings down the next numerator bit and tries one subtraction.
    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            shifted[k] = {rem_reg[k], low_reg[k][QB-1]};
            ge[k]      = (shifted[k] >= {1'b0, d_reg[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_reg <= acc[ACC_W-1];
            a_mag_reg <= acc[ACC_W-1] ? (~acc + 1'b1) : acc;
            a_n_reg   <= norm;

            b_neg_reg <= a_neg_reg;
            b_num_reg <= {1'b0, a_mag_reg, 1'b0} + NUM_W'(a_n_reg);
            b_d_reg   <= {a_n_reg, 1'b0};

            // A quotient wider than the divider produces saturates.
            ovf_reg[0] <= (hi_ext >= d_ext);
            rem_reg[0] <= D_W'(hi_ext);
            d_reg[0]   <= b_d_reg;
            q_reg[0]   <= '0;
            low_reg[0] <= b_num_reg[QB-1:0];
            neg_reg[0] <= b_neg_reg;

            for (int k = 0; k < QB; k++)
            begin
                rem_reg[k+1] <= ge[k] ? D_W'(shifted[k] - {1'b0, d_reg[k]}) : D_W'(shifted[k]);
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge[k]};
                low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb
    begin
        lim = neg_reg[QB] ? QB'(OUT_MIN_MAG) : QB'(OUT_MAX_MAG);
        if (ovf_reg[QB] || (q_reg[QB] > lim))
        begin
            mag_sat = lim;
        end
        else
        begin
            mag_sat = q_reg[QB];
        end
        fin = neg_reg[QB] ? (~mag_sat + 1'b1) : mag_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= fin[OUT_W-1:0];
        end
    end

    assign rot = rot_reg;

endmodule

`default_nettype wire

// ===== design/qvr_back.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate back end
// Three divider lanes in lockstep with a valid and zero-flag pipeline; the
// last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_back
    import qvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire qvr_item_t         item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [OUT_W-1:0] rot_x,
    output logic signed [OUT_W-1:0] rot_y,
    output logic signed [OUT_W-1:0] rot_z,
    output logic                   zero_quat
);

    logic                    en;
    logic [BACK_LAT-1:0]     valid_reg;
    logic [BACK_LAT-1:0]     zero_reg;
    logic signed [OUT_W-1:0] dx, dy, dz;

    assign en  = !valid_reg[BACK_LAT-1] || out_ready;
    assign pop = en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[BACK_LAT-2:0], !empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[BACK_LAT-2:0], item.zero};
        end
    end

    qvr_div u_div_x (.clk(clk), .en(en), .acc(item.acc_x), .norm(item.norm), .rot(dx));
    qvr_div u_div_y (.clk(clk), .en(en), .acc(item.acc_y), .norm(item.norm), .rot(dy));
    qvr_div u_div_z (.clk(clk), .en(en), .acc(item.acc_z), .norm(item.norm), .rot(dz));

    assign out_valid = valid_reg[BACK_LAT-1];
    assign zero_quat = zero_reg[BACK_LAT-1];
    assign rot_x     = zero_quat ? '0 : dx;
    assign rot_y     = zero_quat ? '0 : dy;
    assign rot_z     = zero_quat ? '0 : dz;

endmodule

`default_nettype wire

// ===== design/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate
// Rotates a 16-bit vector by a Q2.14 quaternion, normalized on the fly.
// ----------------------------------------------------------------------------
// The block accepts one quaternion and vector per clock and returns one
// rotated vector per clock while the output is not stalled, rounded to
// nearest with ties away from zero. A transaction passes through the front
// end (products, rotation matrix, matrix times vector, row sums), the
// four-entry queue and the back end, whose pipelined restoring dividers
// produce one quotient bit per stage; the output register holds a stalled
// result while the front end keeps accepting input until the queue fills.
// An all-zero quaternion returns a zero vector with the zero_quat flag set.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z from the lowest bit
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // rot_x, rot_y, rot_z from the lowest bit, then zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // zero_quat
    output logic                       m_axis_tuser
);

    qvr_item_t               f_item, q_item;
    logic                    push, full, pop, empty;
    logic signed [OUT_W-1:0] rot_x, rot_y, rot_z;

    qvr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .quat_w   (s_axis_tdata[0*CW +: CW]),
        .quat_x   (s_axis_tdata[1*CW +: CW]),
        .quat_y   (s_axis_tdata[2*CW +: CW]),
        .quat_z   (s_axis_tdata[3*CW +: CW]),
        .vec_x    (s_axis_tdata[4*CW +: CW]),
        .vec_y    (s_axis_tdata[5*CW +: CW]),
        .vec_z    (s_axis_tdata[6*CW +: CW]),
        .push     (push),
        .full     (full),
        .item     (f_item)
    );

    qvr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (f_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_item  (q_item)
    );

    qvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .item      (q_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .zero_quat (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_DATA_W'({rot_z, rot_y, rot_x});

endmodule

`default_nettype wire

// ===== design/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotate checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_checker
    import qvr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A zero quaternion yields a zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3*OUT_W-1:0] == '0)
        else $error("zero quaternion with nonzero vector");

    // A rotation keeps the length, so no component can reach the negative saturation bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[OUT_W-1:0]) != -65536
                       && $signed(m_axis_tdata[2*OUT_W-1:OUT_W]) != -65536
                       && $signed(m_axis_tdata[3*OUT_W-1:2*OUT_W]) != -65536)
        else $error("rotated component saturated");

    // The zero fill above the three components stays clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:3*OUT_W] == '0)
        else $error("padding bits set");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
